### rtl/core/gf2_matrix_multiply_macros.svh
// Assertion helpers for the GF(2) matrix multiplier.
`ifndef GF2_MATRIX_MULTIPLY_MACROS_SVH
`define GF2_MATRIX_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS

`define GF2MM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gf2mm check failed");

`define GF2MM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gf2mm check failed");

`else

`define GF2MM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GF2MM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/gf2mm_pkg.sv
`timescale 1ns / 1ps
package gf2mm_pkg;

  localparam int MAX_SIZE_DEF = 32;
  localparam int FIELD_ROWS   = 32;
  localparam int ROW_NUM_W    = 5;
  localparam int ROW_BITS_W   = 32;
  localparam int SIZE_W       = 6;
  localparam int CMD_W        = 2;
  localparam int TDATA_W      = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  // Tag that rides along with one product row through the pipeline.
  typedef struct packed {
    logic                 vld;
    logic [ROW_NUM_W-1:0] idx;
    logic                 last;
  } row_tag_t;

  // Ones in the low n bit positions.
  function automatic logic [ROW_BITS_W-1:0] col_mask(input logic [SIZE_W-1:0] n);
    logic [ROW_BITS_W-1:0] mask;
    for (int b = 0; b < ROW_BITS_W; b++) begin
      mask[b] = (SIZE_W'(b) < n);
    end
    return mask;
  endfunction

endpackage

### rtl/core/gf2mm_lane.sv
`timescale 1ns / 1ps
// One output column: parity of (A row AND B column), registered.
module gf2mm_lane import gf2mm_pkg::*; #(
  parameter int ROWS = MAX_SIZE_DEF
) (
  input  logic            clk,
  input  logic            en,
  input  logic [ROWS-1:0] arow,
  input  logic [ROWS-1:0] bcol,
  output logic            par
);

  always_ff @(posedge clk) begin
    if (en) begin
      par <= ^(arow & bcol);
    end
  end

endmodule

### rtl/core/gf2mm_merge.sv
`timescale 1ns / 1ps
// Gathers the lane bits into one product row, masks unused columns and
// holds the result item for the downstream side.
module gf2mm_merge import gf2mm_pkg::*; #(
  parameter int ROWS = MAX_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  row_tag_t           tag,
  input  logic [ROWS-1:0]    lane_bits,
  input  logic [SIZE_W-1:0]  eff_size,
  output logic               m_tvalid,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);

  logic [ROW_BITS_W-1:0] cmask;
  logic [ROW_BITS_W-1:0] product;

  always_comb begin
    cmask   = col_mask(eff_size);
    product = ROW_BITS_W'(lane_bits) & cmask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(TDATA_W - ROW_BITS_W - ROW_NUM_W)'(0), product, tag.idx};
      m_tlast <= tag.last;
    end
  end

endmodule

### rtl/core/gf2_matrix_multiply.sv
// GF(2) square bit-matrix multiplier, C = A * B (AND products, XOR sums).
// Input stream s_*: s_tuser holds the command, s_tdata the row number and
// row bits. Load-A and load-B items write one row each; rows at or above the
// size in use are dropped. A compute item emits the product on m_* one row
// per cycle while m_tready is high, row index and bits in m_tdata, m_tlast on
// the final row. Columns at or above the size in use read as zero.
// Configuration: cfg_valid/cfg_data sets the size in use (always ready);
// write it only while no compute is in flight.
// Flow: a compute item passes the row counter, the A-row register, the lane
// registers and the output register; rows then follow one per cycle while
// m_tready is high, and no new item is taken until the last row has reached
// the output register. One row per cycle is set by the column lanes: every
// column of a row is formed at once, rows go through one at a time.
// Reset clears the size in use to 32 (limited to MAX_SIZE) and flushes the
// pipeline; the matrices hold no reset value and a row must be loaded before
// a compute reads it.
// When m_tready is low with a row in the output register, the whole row
// pipeline stalls and holds; a row held there does not block load items.
`timescale 1ns / 1ps
`include "gf2_matrix_multiply_macros.svh"
module gf2_matrix_multiply import gf2mm_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SIZE_W-1:0]  cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [4:0] row_number, [36:5] row_bits
  input  logic [CMD_W-1:0]   s_tuser,   // [1:0] command
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [4:0] out_row, [36:5] product_row
  output logic               m_tlast
);

  localparam int ROWS  = (MAX_SIZE < FIELD_ROWS) ? MAX_SIZE : FIELD_ROWS;
  localparam int ROW_W = $clog2(ROWS);

  logic [SIZE_W-1:0]     eff_size;
  logic [ROW_BITS_W-1:0] mat_a [ROWS];
  logic [ROW_BITS_W-1:0] mat_b [ROWS];
  logic [ROWS-1:0]       bcol [ROWS];

  cmd_t                  cmd;
  logic [ROW_NUM_W-1:0]  row_num;
  logic [ROW_BITS_W-1:0] row_bits;
  logic                  row_ok;
  logic                  s_acc;
  logic                  adv;

  logic                  busy;
  logic [ROW_W-1:0]      cnt;
  logic                  issue_last;
  logic [ROW_BITS_W-1:0] a_sel;
  logic [ROW_BITS_W-1:0] cmask;

  logic                  v1;
  logic [ROW_NUM_W-1:0]  idx1;
  logic                  last1;
  logic [ROWS-1:0]       arow1;
  row_tag_t              tag2;
  logic [ROWS-1:0]       lane_bits;

  assign cfg_ready = 1'b1;
  assign cmd       = cmd_t'(s_tuser);
  assign row_num   = s_tdata[ROW_NUM_W-1:0];
  assign row_bits  = s_tdata[ROW_NUM_W +: ROW_BITS_W];
  assign row_ok    = SIZE_W'(row_num) < eff_size;
  assign s_tready  = !busy && !v1 && !tag2.vld;
  assign s_acc     = s_tvalid && s_tready;
  assign adv       = !m_tvalid || m_tready;

  assign issue_last = (SIZE_W'(cnt) + SIZE_W'(1)) == eff_size;
  assign a_sel      = mat_a[cnt];
  assign cmask      = col_mask(eff_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_size <= SIZE_W'(ROWS);
    end else if (cfg_valid && cfg_ready) begin
      eff_size <= (cfg_data > SIZE_W'(ROWS)) ? SIZE_W'(ROWS) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && row_ok) begin
      case (cmd)
        CMD_LOAD_A: mat_a[row_num[ROW_W-1:0]] <= row_bits;
        CMD_LOAD_B: mat_b[row_num[ROW_W-1:0]] <= row_bits;
        default: ;
      endcase
    end
  end

  // Column j of B as seen by lane j: fixed wiring, no read port.
  always_comb begin
    for (int j = 0; j < ROWS; j++) begin
      for (int k = 0; k < ROWS; k++) begin
        bcol[j][k] = mat_b[k][j];
      end
    end
  end

  // Row sequencer and pipeline control; all but the start of a compute moves on adv.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      v1    <= 1'b0;
      idx1  <= '0;
      last1 <= 1'b0;
      tag2  <= '0;
    end else begin
      if (s_acc && cmd == CMD_COMPUTE && eff_size != '0) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (adv && busy) begin
        if (issue_last) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + ROW_W'(1);
        end
      end
      if (adv) begin
        v1    <= busy;
        idx1  <= ROW_NUM_W'(cnt);
        last1 <= issue_last;
        tag2  <= '{vld: v1, idx: idx1, last: last1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arow1 <= a_sel[ROWS-1:0] & cmask[ROWS-1:0];
    end
  end

  for (genvar j = 0; j < ROWS; j++) begin : g_lane
    gf2mm_lane #(.ROWS(ROWS)) u_lane (
      .clk  (clk),
      .en   (adv),
      .arow (arow1),
      .bcol (bcol[j]),
      .par  (lane_bits[j])
    );
  end

  gf2mm_merge #(.ROWS(ROWS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag       (tag2),
    .lane_bits (lane_bits),
    .eff_size  (eff_size),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  `GF2MM_ASSERT_NEXT(a_compute_starts, clk, rst, s_acc && cmd == CMD_COMPUTE && eff_size != '0, busy && cnt == '0)
  `GF2MM_ASSERT_IMPL(a_no_last_while_busy, clk, rst, busy && v1, !last1)
  `GF2MM_ASSERT_IMPL(a_last_row_index, clk, rst, m_tvalid && m_tlast, m_tdata[ROW_NUM_W-1:0] == ROW_NUM_W'(eff_size - SIZE_W'(1)))
  `GF2MM_ASSERT_IMPL(a_row_in_range, clk, rst, m_tvalid, SIZE_W'(m_tdata[ROW_NUM_W-1:0]) < eff_size)

endmodule
